// ===== design/rrtq_pkg.sv =====
// Package for the round-robin task queue.
// Holds the command codes and the status flag bundle; no dependencies.
`default_nettype none

package rrtq_pkg;

  localparam int unsigned CMD_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  // Status of one queue operation, passed from the control unit to the top level.
  typedef struct packed {
    logic wr_en;
    logic accepted;
    logic head_valid;
    logic overflow;
    logic bypass;
  } ctrl_flags_t;

endpackage

`default_nettype wire

// ===== design/rrtq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Read-first: a read and a write to the same address return the old data.
// No dependencies.
`default_nettype none

module rrtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/rrtq_ctrl.sv =====
// Queue control: head pointer, occupancy and overflow flag, and the
// next-state logic for one command. Depends on rrtq_pkg.
`default_nettype none

module rrtq_ctrl #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned TASK_ID_BITS = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              step_i,
  input  wire logic [rrtq_pkg::CMD_W-1:0]        cmd_i,
  input  wire logic [TASK_ID_BITS-1:0]           task_id_i,
  input  wire logic                              task_done_i,
  input  wire logic [TASK_ID_BITS-1:0]           cur_head_i,
  output logic      [$clog2(QUEUE_DEPTH)-1:0]    waddr_o,
  output logic      [TASK_ID_BITS-1:0]           wdata_o,
  output logic      [$clog2(QUEUE_DEPTH)-1:0]    raddr_o,
  output logic      [$clog2(QUEUE_DEPTH+1)-1:0]  count_o,
  output rrtq_pkg::ctrl_flags_t                  flags_o
);

  import rrtq_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SumW = PtrW + 1;
  localparam logic [SumW-1:0] DepthS  = SumW'(QUEUE_DEPTH);
  localparam logic [CntW-1:0] DepthC  = CntW'(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [SumW-1:0] tail_sum;
  logic [PtrW-1:0] tail;
  logic [PtrW-1:0] head_inc;
  logic            we;
  logic            accepted;

  // The tail slot is head plus count, wrapped once.
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  assign tail     = (tail_sum >= DepthS) ? PtrW'(tail_sum - DepthS) : PtrW'(tail_sum);
  assign head_inc = (head_q == LastPtr) ? '0 : head_q + PtrW'(1);

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    we       = 1'b0;
    wdata_o  = task_id_i;
    accepted = 1'b0;
    unique case (cmd_i)
      CMD_ADD: begin
        if (count_q == DepthC) begin
          ovf_d = 1'b1;
        end else begin
          we       = 1'b1;
          count_d  = count_q + CntW'(1);
          accepted = 1'b1;
        end
      end
      CMD_FINISH: begin
        if (count_q != '0) begin
          head_d   = head_inc;
          accepted = 1'b1;
          if (task_done_i) begin
            count_d = count_q - CntW'(1);
          end else begin
            // The head task goes back in at the old tail; the count is unchanged.
            we      = 1'b1;
            wdata_o = cur_head_i;
          end
        end
      end
      CMD_CLEAR: begin
        head_d   = '0;
        count_d  = '0;
        ovf_d    = 1'b0;
        accepted = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      head_q  <= head_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign waddr_o            = tail;
  assign raddr_o            = head_d;
  assign count_o            = count_d;
  assign flags_o.wr_en      = we;
  assign flags_o.accepted   = accepted;
  assign flags_o.head_valid = (count_d != '0);
  assign flags_o.overflow   = ovf_d;
  assign flags_o.bypass     = we && (tail == head_d);

endmodule

`default_nettype wire

// ===== design/round_robin_task_queue.sv =====
// Top level of the round-robin task queue: command channel in, status channel out.
// Depends on rrtq_pkg, rrtq_ctrl and rrtq_ram.
//
//   Channel  Handshake                 Payload
//   -------  ------------------------  ------------------------------------------------
//   command  in_valid_i / in_ready_o   cmd_i, task_id_i, task_done_i
//   status   out_valid_o / out_ready_i head_task_o, head_valid_o, queued_count_o,
//                                      overflow_seen_o, op_accepted_o
//
// One command per cycle while in_ready_o is high; its status is captured in the output
// register at the transfer. The queue state and the slot RAM update at the transfer,
// and the RAM read of the new head lands in its read register at the same edge.
// Reset clears the pointers, the count, the overflow flag and the output valid;
// the slot RAM is not cleared and needs no clearing pass.
// While a status waits and out_ready_i is low, in_ready_o is low as well.
`default_nettype none

module round_robin_task_queue #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned TASK_ID_BITS = 8
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [rrtq_pkg::CMD_W-1:0]       cmd_i,
  input  wire logic [TASK_ID_BITS-1:0]          task_id_i,
  input  wire logic                             task_done_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [TASK_ID_BITS-1:0]          head_task_o,
  output logic                                  head_valid_o,
  output logic      [$clog2(QUEUE_DEPTH+1)-1:0] queued_count_o,
  output logic                                  overflow_seen_o,
  output logic                                  op_accepted_o
);

  import rrtq_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic                    in_xfer;
  logic [PtrW-1:0]         waddr;
  logic [TASK_ID_BITS-1:0] wdata;
  logic [PtrW-1:0]         raddr;
  logic [CntW-1:0]         count_d;
  ctrl_flags_t             flags;
  logic [TASK_ID_BITS-1:0] ram_rdata;
  logic [TASK_ID_BITS-1:0] cur_head;

  // Result register.
  logic                    out_valid_q;
  logic [CntW-1:0]         count_q;
  logic                    head_valid_q;
  logic                    ovf_q;
  logic                    accepted_q;
  // When the slot just written is also the new head, the RAM read returns the
  // old contents, so the written value is kept here and chosen instead.
  logic                    bypass_q;
  logic [TASK_ID_BITS-1:0] bypass_data_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  rrtq_ctrl #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_xfer),
    .cmd_i       (cmd_i),
    .task_id_i   (task_id_i),
    .task_done_i (task_done_i),
    .cur_head_i  (cur_head),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .count_o     (count_d),
    .flags_o     (flags)
  );

  rrtq_ram #(
    .WIDTH (TASK_ID_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (in_xfer && flags.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (in_xfer),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // The head of the current queue state: both the RAM read register and the
  // bypass register only change at a transfer, so this stays valid while the
  // status is stalled and is what a requeue writes back at the tail.
  assign cur_head = bypass_q ? bypass_data_q : ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      head_valid_q <= 1'b0;
      ovf_q        <= 1'b0;
      accepted_q   <= 1'b0;
      bypass_q     <= 1'b0;
    end else begin
      if (in_xfer) begin
        out_valid_q  <= 1'b1;
        count_q      <= count_d;
        head_valid_q <= flags.head_valid;
        ovf_q        <= flags.overflow;
        accepted_q   <= flags.accepted;
        bypass_q     <= flags.bypass;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      bypass_data_q <= wdata;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign head_task_o     = head_valid_q ? cur_head : '0;
  assign head_valid_o    = head_valid_q;
  assign queued_count_o  = count_q;
  assign overflow_seen_o = ovf_q;
  assign op_accepted_o   = accepted_q;

`ifndef SYNTHESIS
  // The occupancy never goes beyond the number of slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (count_q <= CntW'(QUEUE_DEPTH)))
    else $error("queued count exceeds the queue depth");

  // The head is reported valid exactly when tasks are queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (head_valid_q == (count_q != '0)))
    else $error("head valid disagrees with queued count");

  // An add either takes effect or leaves the overflow flag set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (cmd_i == CMD_ADD)) |=> (accepted_q || ovf_q))
    else $error("add neither accepted nor flagged as overflow");

  // A clear always empties the queue and drops the overflow flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (cmd_i == CMD_CLEAR)) |=> ((count_q == '0) && !ovf_q && accepted_q))
    else $error("clear did not empty the queue");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the round-robin task queue.
// Drives the command channel, predicts each status transfer and checks it field by field.
// Depends on rrtq_pkg and round_robin_task_queue.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rrtq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned ID_BITS      = 8;
  localparam int unsigned CNT_BITS     = $clog2(DEPTH + 1);
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned SEGMENT      = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE       = 10;

  // The package names only the three live commands; code 3 must be ignored.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Bias of one random segment: grow the queue, shrink it, or mix evenly.
  localparam int unsigned MIX_FILL    = 0;
  localparam int unsigned MIX_DRAIN   = 1;
  localparam int unsigned MIX_BALANCE = 2;

  typedef struct packed {
    logic [ID_BITS-1:0]  head;
    logic                head_valid;
    logic [CNT_BITS-1:0] count;
    logic                overflow;
    logic                accepted;
  } status_t;

  // One row of the directed table. When typed is set, status holds the
  // expected transfer written by hand; otherwise the queue model decides.
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ID_BITS-1:0] id;
    logic               done;
    logic               typed;
    status_t            status;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd = CMD_CLEAR;
  logic [ID_BITS-1:0]  task_id = '0;
  logic                task_done = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ID_BITS-1:0]  head_task;
  logic                head_valid;
  logic [CNT_BITS-1:0] queued_count;
  logic                overflow_seen;
  logic                op_accepted;

  // Model of the queue: a circular buffer with a head index and an occupancy.
  logic [ID_BITS-1:0]  slot_ids [DEPTH];
  logic [CNT_BITS-1:0] held;
  logic                sticky_overflow;
  logic [3:0]          head_idx;

  // Status transfers that the design still owes, oldest first.
  status_t     owed_status [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  // While set, neither side inserts idle cycles.
  bit          quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  round_robin_task_queue #(
    .QUEUE_DEPTH  (DEPTH),
    .TASK_ID_BITS (ID_BITS)
  ) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (cmd),
    .task_id_i       (task_id),
    .task_done_i     (task_done),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .head_task_o     (head_task),
    .head_valid_o    (head_valid),
    .queued_count_o  (queued_count),
    .overflow_seen_o (overflow_seen),
    .op_accepted_o   (op_accepted)
  );

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic queue_clear();
    held = '0;
    sticky_overflow = 1'b0;
    head_idx = '0;
  endtask

  // The tail slot sits held entries past the head; the 4-bit index wraps by itself.
  task automatic queue_push(input logic [ID_BITS-1:0] id);
    logic [3:0] tail;
    tail = head_idx + held[3:0];
    slot_ids[tail] = id;
    held++;
  endtask

  // Applies one command to the queue model and returns the status it reports.
  task automatic queue_apply(input logic [CMD_W-1:0] c, input logic [ID_BITS-1:0] id,
                             input logic dn, output status_t st);
    logic [ID_BITS-1:0] retired;
    logic               took;
    took = 1'b0;
    case (c)
      CMD_ADD: begin
        if (held >= CNT_BITS'(DEPTH)) begin
          sticky_overflow = 1'b1;
        end else begin
          queue_push(id);
          took = 1'b1;
        end
      end
      CMD_FINISH: begin
        // The head leaves before a requeue, so a full queue can still rotate.
        if (held != 0) begin
          retired = slot_ids[head_idx];
          head_idx++;
          held--;
          if (!dn) begin
            queue_push(retired);
          end
          took = 1'b1;
        end
      end
      CMD_CLEAR: begin
        queue_clear();
        took = 1'b1;
      end
      default: begin
      end
    endcase
    st.head       = (held != 0) ? slot_ids[head_idx] : '0;
    st.head_valid = (held != 0);
    st.count      = held;
    st.overflow   = sticky_overflow;
    st.accepted   = took;
  endtask

  // Most gaps are short, a few are long, and quiet segments have none.
  function automatic int unsigned gap_len();
    int unsigned r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 10);
  endfunction

  // Offers one command after a random gap and waits for its transfer. The
  // expectation is recorded at the transfer edge, before the earliest status
  // can come back.
  task automatic issue(input logic [CMD_W-1:0] c, input logic [ID_BITS-1:0] id,
                       input logic dn, input logic typed, input status_t typed_status);
    int unsigned gap;
    status_t     predicted;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    task_id   <= id;
    task_done <= dn;
    do @(posedge clk); while (!in_ready);
    queue_apply(c, id, dn, predicted);
    owed_status.push_back(typed ? typed_status : predicted);
  endtask

  // Holds the command channel idle until every owed status has come back.
  task automatic wait_for_outstanding();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_status.size() != 0);
  endtask

  function automatic step_t make_step(input logic [CMD_W-1:0] c, input logic [ID_BITS-1:0] id,
                                      input logic dn, input logic typed,
                                      input logic [ID_BITS-1:0] head, input logic hv,
                                      input logic [CNT_BITS-1:0] count, input logic ovf,
                                      input logic acc);
    step_t s;
    s.cmd               = c;
    s.id                = id;
    s.done              = dn;
    s.typed             = typed;
    s.status.head       = head;
    s.status.head_valid = hv;
    s.status.count      = count;
    s.status.overflow   = ovf;
    s.status.accepted   = acc;
    return s;
  endfunction

  // Status side: check every transfer against the oldest expectation, then
  // decide whether to stall for the coming cycles.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{head_task, head_valid, queued_count, overflow_seen, op_accepted};
      if (owed_status.size() == 0) begin
        report_mismatch("status transfer with nothing expected");
      end else begin
        want = owed_status.pop_front();
        check_field("head_task", 32'(got.head), 32'(want.head));
        check_field("head_valid", 32'(got.head_valid), 32'(want.head_valid));
        check_field("queued_count", 32'(got.count), 32'(want.count));
        check_field("overflow_seen", 32'(got.overflow), 32'(want.overflow));
        check_field("op_accepted", 32'(got.accepted), 32'(want.accepted));
      end
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(99) < 15) begin
        stall_left = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    step_t            steps [$];
    int unsigned      mix;
    int unsigned      pick;
    logic [CMD_W-1:0] c;

    queue_clear();

    // Directed table. Rows with a typed status cover reset, empty finishes,
    // the unused code, clear, and an add refused by a full queue. The run of
    // adds fills all sixteen slots with ids that toggle every bit, and the
    // finish after the refused add rotates the head of a full queue.
    steps = '{
      make_step(CMD_FINISH, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_UNUSED, 8'hA5, 1'b1, 1'b1, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_CLEAR,  8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 5'd0,  1'b0, 1'b1),
      make_step(CMD_ADD,    8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, 5'd1,  1'b0, 1'b1),
      make_step(CMD_ADD,    8'h00, 1'b1, 1'b1, 8'hFF, 1'b1, 5'd2,  1'b0, 1'b1),
      make_step(CMD_ADD,    8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'h02, 1'b1, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'h04, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'h08, 1'b1, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'h10, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'h20, 1'b1, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'h40, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'h80, 1'b1, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'h55, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'hAA, 1'b1, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'h0F, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'hF0, 1'b1, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'h3C, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'hC3, 1'b1, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_ADD,    8'h77, 1'b0, 1'b1, 8'hFF, 1'b1, 5'd16, 1'b1, 1'b0),
      make_step(CMD_FINISH, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_UNUSED, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_FINISH, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0),
      make_step(CMD_CLEAR,  8'hFF, 1'b1, 1'b1, 8'h00, 1'b0, 5'd0,  1'b0, 1'b1),
      make_step(CMD_FINISH, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0)
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      issue(steps[i].cmd, steps[i].id, steps[i].done, steps[i].typed, steps[i].status);
    end

    // Random part in segments. Each segment leans toward filling or
    // draining, or mixes evenly, so the queue keeps reaching both full and
    // empty, and clears stay rare enough not to cut every fill short.
    mix = MIX_BALANCE;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % SEGMENT == 0) begin
        mix   = $urandom_range(MIX_BALANCE);
        quiet = ($urandom_range(4) == 0);
      end
      // Twice the sender stops until every status has been returned.
      if (i == 300 || i == 650) begin
        wait_for_outstanding();
      end
      pick = $urandom_range(99);
      if (pick < 2) begin
        c = CMD_CLEAR;
      end else if (pick < 4) begin
        c = CMD_UNUSED;
      end else if (mix == MIX_FILL) begin
        c = (pick < 78) ? CMD_ADD : CMD_FINISH;
      end else if (mix == MIX_DRAIN) begin
        c = (pick < 24) ? CMD_ADD : CMD_FINISH;
      end else begin
        c = (pick < 52) ? CMD_ADD : CMD_FINISH;
      end
      issue(c, ID_BITS'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (owed_status.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
